[rtl/core/lrps_pkg.sv]
// ----------------------------------------------------------------------------
// lrps_pkg: shared definitions for the light ramp and pump scheduler
// Widths, register indexes, reset values, control and status bundles and
// the percent to drive level conversion.
// ----------------------------------------------------------------------------
`default_nettype none

package lrps_pkg;

  localparam int DRV_W     = 8;
  localparam int PCT_W     = 7;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int MOD_W     = 11;  // minute of day, up to 31*60+63
  localparam int SMOD_W    = 13;  // signed minute of day with ramp offsets
  localparam int RAMP_W    = 7;
  localparam int SETUP_W   = 18;
  localparam int SECS_W    = 6;
  localparam int LIMIT_W   = 16;  // seconds*1000 stays below 2^16
  localparam int NOW_W     = 32;
  localparam int CFG_W     = 28;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_CH    = 4;
  localparam int CH_W      = 2;
  localparam int NUM_PUMP  = 2;
  localparam int NUM_W     = DRV_W + RAMP_W;
  localparam int QUO_W     = DRV_W;
  localparam int DIV_STEPS = QUO_W;

  localparam int TIME_BITS_DEF = 32;

  localparam int MIN_PER_HOUR  = 60;
  localparam int MS_PER_SEC    = 1000;
  localparam int PCT_FULL      = 100;
  localparam int DRV_FULL      = 255;
  // floor(x/100) for x up to 25500 equals (x*5243) >> 19.
  localparam int RECIP_100     = 5243;
  localparam int RECIP_SHIFT   = 19;
  localparam int SCALED_W      = 15;
  localparam int PROD_W        = RECIP_SHIFT + DRV_W;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HOUR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_HOUR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_MINUTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_ONE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUMP_TWO     = 3'd5;

  localparam logic [CFG_W-1:0]   RST_LIGHT_LEVELS = 28'd0;
  localparam logic [HOUR_W-1:0]  RST_START_HOUR   = 5'd8;
  localparam logic [HOUR_W-1:0]  RST_END_HOUR     = 5'd20;
  localparam logic [RAMP_W-1:0]  RST_RAMP_MINUTES = 7'd30;
  localparam logic [SETUP_W-1:0] RST_PUMP_ONE     = 18'd102569;
  localparam logic [SETUP_W-1:0] RST_PUMP_TWO     = 18'd102575;

  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_HOLD = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_OFF  = 2'd3;

  typedef struct packed {
    logic            accept;
    logic            prep;
    logic            div_start;
    logic            store;
    logic [CH_W-1:0] ch;
    logic            publish;
  } lrps_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic div_done;
    logic out_busy;
  } lrps_sts_t;

  function automatic logic [DRV_W-1:0] pct_to_drive(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0]    sat;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    sat    = (pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct;
    scaled = SCALED_W'(sat) * SCALED_W'(DRV_FULL);
    prod   = PROD_W'(scaled) * PROD_W'(RECIP_100);
    return prod[PROD_W-1:RECIP_SHIFT];
  endfunction

endpackage

`default_nettype wire

[rtl/core/light_ramp_pump_scheduler.sv]
// ----------------------------------------------------------------------------
// light_ramp_pump_scheduler: daily light ramps and timed pump runs
// Turns each clock tick into four light drive levels and two pump drive
// levels, one result per tick.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Contents
//   in_       input       in_valid/in_ready    hour, minute, millisecond time
//   out_      output      out_valid/out_ready  four light levels, two pumps
//   cfg_      input       cfg_we               register index and write data
//
// From acceptance to the result register an item goes through these steps:
// it is taken in, the ramp segment is decoded, then each of the four light
// channels is worked on in turn, through the shared divider when the minute
// falls on a ramp, and the result is published. The shared one-bit-per-cycle
// divider makes the items that fall on a ramp the slowest.
// Reset is synchronous and active low; it restores the register defaults
// and disarms both pumps. A result that waits on out_ready holds the block
// in its last step. The input side stays open until one more item is taken;
// that item is then worked on and waits in the last step behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module light_ramp_pump_scheduler
  import lrps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Configuration writes: only while the block is idle, a rule the user must keep.
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Tick items.
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [HOUR_W-1:0]    in_hour_now,
  input  wire logic [MIN_W-1:0]     in_minute_now,
  input  wire logic [NOW_W-1:0]     in_now_ms,
  // Result items.
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [DRV_W-1:0]          out_red_level,
  output logic [DRV_W-1:0]          out_green_level,
  output logic [DRV_W-1:0]          out_blue_level,
  output logic [DRV_W-1:0]          out_white_level,
  output logic [DRV_W-1:0]          out_pump_one_drive,
  output logic [DRV_W-1:0]          out_pump_two_drive
);

  // The sequencer issues one command bundle per cycle and watches the
  // datapath's status; nothing else passes between the two.
  lrps_cmd_t cmd;
  lrps_sts_t sts;

  lrps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the configuration, the pump timers of TIME_BITS
  // bits, the per-channel levels, the divider and the output register.
  lrps_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_hour_now        (in_hour_now),
    .in_minute_now      (in_minute_now),
    .in_now_ms          (in_now_ms),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_red_level      (out_red_level),
    .out_green_level    (out_green_level),
    .out_blue_level     (out_blue_level),
    .out_white_level    (out_white_level),
    .out_pump_one_drive (out_pump_one_drive),
    .out_pump_two_drive (out_pump_two_drive)
  );

endmodule

`default_nettype wire

[rtl/core/lrps_div.sv]
// ----------------------------------------------------------------------------
// lrps_div: iterative ramp divider
// Restoring division, one quotient bit per cycle. The quotient is known to
// fit in QUO_W bits, so the upper dividend bits preload the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_div
  import lrps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [RAMP_W-1:0] den,
  output logic                   busy,
  output logic                   done,
  output logic [QUO_W-1:0]       quo
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RAMP_W-1:0] rem_r, rem_nxt;
  logic [RAMP_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0]  q_r, q_nxt;
  logic [RAMP_W:0]   trial;
  logic [RAMP_W:0]   diff;

  always_comb begin
    trial    = {rem_r, q_r[QUO_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_STEPS);
      rem_nxt  = num[NUM_W-1:QUO_W];
      q_nxt    = num[QUO_W-1:0];
      den_nxt  = den;
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[RAMP_W-1:0];
        q_nxt   = {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RAMP_W-1:0];
        q_nxt   = {q_r[QUO_W-2:0], 1'b0};
      end
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign done = busy_r && (cnt_r == '0);
  assign quo  = q_r;

  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && (cnt_r == CNT_W'(DIV_STEPS))))
    else $error("divider did not load on start");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r))
    else $error("divider remainder reached the divisor");

endmodule

`default_nettype wire

[rtl/core/lrps_dp.sv]
// ----------------------------------------------------------------------------
// lrps_dp: scheduler datapath
// Configuration registers, pump timers, ramp segment decode, channel levels,
// the shared divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_dp
  import lrps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic [HOUR_W-1:0]    in_hour_now,
  input  wire logic [MIN_W-1:0]     in_minute_now,
  input  wire logic [NOW_W-1:0]     in_now_ms,
  input  wire lrps_cmd_t            cmd,
  output lrps_sts_t                 sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [DRV_W-1:0]          out_red_level,
  output logic [DRV_W-1:0]          out_green_level,
  output logic [DRV_W-1:0]          out_blue_level,
  output logic [DRV_W-1:0]          out_white_level,
  output logic [DRV_W-1:0]          out_pump_one_drive,
  output logic [DRV_W-1:0]          out_pump_two_drive
);

  // Configuration registers.
  logic [CFG_W-1:0]   light_levels_r;
  logic [HOUR_W-1:0]  start_hour_r;
  logic [HOUR_W-1:0]  end_hour_r;
  logic [RAMP_W-1:0]  ramp_r;
  logic [SETUP_W-1:0] pump_setup_r [NUM_PUMP];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_levels_r  <= RST_LIGHT_LEVELS;
      start_hour_r    <= RST_START_HOUR;
      end_hour_r      <= RST_END_HOUR;
      ramp_r          <= RST_RAMP_MINUTES;
      pump_setup_r[0] <= RST_PUMP_ONE;
      pump_setup_r[1] <= RST_PUMP_TWO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_LEVELS: light_levels_r  <= cfg_data;
        REG_START_HOUR:   start_hour_r    <= cfg_data[HOUR_W-1:0];
        REG_END_HOUR:     end_hour_r      <= cfg_data[HOUR_W-1:0];
        REG_RAMP_MINUTES: ramp_r          <= cfg_data[RAMP_W-1:0];
        REG_PUMP_ONE:     pump_setup_r[0] <= cfg_data[SETUP_W-1:0];
        REG_PUMP_TWO:     pump_setup_r[1] <= cfg_data[SETUP_W-1:0];
        default:          ;
      endcase
    end
  end

  // Pump timers, evaluated on the accepted item.
  logic [TIME_BITS+NOW_W-1:0] now_ext;
  logic [TIME_BITS-1:0]       now_t;
  logic                       armed_r     [NUM_PUMP];
  logic                       armed_nxt   [NUM_PUMP];
  logic [TIME_BITS-1:0]       start_r     [NUM_PUMP];
  logic [TIME_BITS-1:0]       start_nxt   [NUM_PUMP];
  logic [TIME_BITS-1:0]       elapsed     [NUM_PUMP];
  logic [LIMIT_W-1:0]         limit       [NUM_PUMP];
  logic [DRV_W-1:0]           pump_drv_r  [NUM_PUMP];
  logic [DRV_W-1:0]           pump_drv_nxt[NUM_PUMP];

  assign now_ext = {{TIME_BITS{1'b0}}, in_now_ms};
  assign now_t   = now_ext[TIME_BITS-1:0];

  always_comb begin
    for (int p = 0; p < NUM_PUMP; p++) begin
      armed_nxt[p] = (in_hour_now == pump_setup_r[p][HOUR_W-1:0]) &&
                     (in_minute_now == '0);
      start_nxt[p] = (armed_nxt[p] && !armed_r[p]) ? now_t : start_r[p];
      elapsed[p]   = now_t - start_nxt[p];
      limit[p]     = LIMIT_W'(pump_setup_r[p][HOUR_W +: SECS_W]) * LIMIT_W'(MS_PER_SEC);
      if (armed_nxt[p] &&
          ({{LIMIT_W{1'b0}}, elapsed[p]} < {{TIME_BITS{1'b0}}, limit[p]})) begin
        pump_drv_nxt[p] = pct_to_drive(pump_setup_r[p][HOUR_W+SECS_W +: PCT_W]);
      end else begin
        pump_drv_nxt[p] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PUMP; p++) begin
        armed_r[p] <= 1'b0;
        start_r[p] <= '0;
      end
    end else if (cmd.accept) begin
      for (int p = 0; p < NUM_PUMP; p++) begin
        armed_r[p] <= armed_nxt[p];
        start_r[p] <= start_nxt[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      for (int p = 0; p < NUM_PUMP; p++) begin
        pump_drv_r[p] <= pump_drv_nxt[p];
      end
    end
  end

  // Minute of day of the accepted item.
  logic [MOD_W-1:0] cm_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cm_r <= MOD_W'(in_hour_now) * MOD_W'(MIN_PER_HOUR) + MOD_W'(in_minute_now);
    end
  end

  // Segment decode and full levels.
  logic signed [SMOD_W-1:0] cm_s, sm_s, em_s, tr_s, se_s, ss_s;
  logic signed [SMOD_W-1:0] rise_k, fall_k;
  logic [1:0]               seg_r, seg_nxt;
  logic [RAMP_W-1:0]        k_r, k_nxt;
  logic [DRV_W-1:0]         full_r  [NUM_CH];
  logic [DRV_W-1:0]         full_nxt[NUM_CH];

  always_comb begin
    cm_s   = $signed({2'b00, cm_r});
    sm_s   = $signed(SMOD_W'(start_hour_r) * SMOD_W'(MIN_PER_HOUR));
    em_s   = $signed(SMOD_W'(end_hour_r) * SMOD_W'(MIN_PER_HOUR));
    tr_s   = $signed(SMOD_W'(ramp_r));
    se_s   = sm_s + tr_s;
    ss_s   = em_s - tr_s;
    // On the falling ramp, ramp - (cm - (em - ramp)) reduces to em - cm.
    rise_k = cm_s - sm_s;
    fall_k = em_s - cm_s;
    k_nxt  = '0;
    priority if ((cm_s >= sm_s) && (cm_s < se_s)) begin
      seg_nxt = SEG_RISE;
      k_nxt   = rise_k[RAMP_W-1:0];
    end else if ((cm_s >= se_s) && (cm_s < ss_s)) begin
      seg_nxt = SEG_HOLD;
    end else if ((cm_s >= ss_s) && (cm_s < em_s)) begin
      seg_nxt = SEG_FALL;
      k_nxt   = fall_k[RAMP_W-1:0];
    end else begin
      seg_nxt = SEG_OFF;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      full_nxt[c] = pct_to_drive(light_levels_r[PCT_W*c +: PCT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_OFF;
    end else if (cmd.prep) begin
      seg_r <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      k_r <= k_nxt;
      for (int c = 0; c < NUM_CH; c++) begin
        full_r[c] <= full_nxt[c];
      end
    end
  end

  // Shared divider: full level times ramp position over ramp length.
  logic [NUM_W-1:0] dividend;
  logic             div_busy, div_done;
  logic [QUO_W-1:0] div_quo;

  assign dividend = NUM_W'(full_r[cmd.ch]) * NUM_W'(k_r);

  lrps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dividend),
    .den   (ramp_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Channel levels.
  logic [DRV_W-1:0] level_r [NUM_CH];
  logic [DRV_W-1:0] level_nxt;

  always_comb begin
    unique case (seg_r)
      SEG_RISE, SEG_FALL: level_nxt = div_quo;
      SEG_HOLD:           level_nxt = full_r[cmd.ch];
      default:            level_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      level_r[cmd.ch] <= level_nxt;
    end
  end

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  logic [DRV_W-1:0] out_lvl_r [NUM_CH];
  logic [DRV_W-1:0] out_pump_r[NUM_PUMP];

  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      for (int c = 0; c < NUM_CH; c++) begin
        out_lvl_r[c] <= level_r[c];
      end
      for (int p = 0; p < NUM_PUMP; p++) begin
        out_pump_r[p] <= pump_drv_r[p];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_red_level      = out_lvl_r[0];
  assign out_green_level    = out_lvl_r[1];
  assign out_blue_level     = out_lvl_r[2];
  assign out_white_level    = out_lvl_r[3];
  assign out_pump_one_drive = out_pump_r[0];
  assign out_pump_two_drive = out_pump_r[1];

  assign sts.need_div = (seg_r == SEG_RISE) || (seg_r == SEG_FALL);
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> (!out_valid_r || out_ready))
    else $error("result published over a result not yet taken");

  a_div_on_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> ((seg_r == SEG_RISE) || (seg_r == SEG_FALL)))
    else $error("divider started outside a ramp segment");

endmodule

`default_nettype wire

[rtl/core/lrps_ctrl.sv]
// ----------------------------------------------------------------------------
// lrps_ctrl: scheduler sequencer
// Accepts one item, decodes the segment, walks the four light channels
// (via the divider on a ramp) and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrps_ctrl
  import lrps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output lrps_cmd_t      cmd,
  input  wire lrps_sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_CH   = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

  logic [2:0]      state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cmd           = '0;
    cmd.ch        = ch_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        ch_nxt    = '0;
        state_nxt = ST_CH;
      end
      ST_CH: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.store = 1'b1;
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = (ch_r == CH_LAST) ? ST_FIN : ST_CH;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.store = 1'b1;
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = (ch_r == CH_LAST) ? ST_FIN : ST_CH;
        end
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> sts.div_busy)
    else $error("waiting on a divider that is not running");

  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_PREP))
    else $error("accepted item not followed by segment decode");

endmodule

`default_nettype wire

[bench/light_ramp_pump_scheduler_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// light_ramp_pump_scheduler_tb: self-checking bench for the light and pump
// scheduler
// Walks a short directed table, then several register settings, each with
// random ticks. Pump runs, ticks near the ramps and raw noise are mixed.
// Every accepted tick is scored against its typed table row or an in-bench
// predictor. Random gaps are applied on both handshakes.
// ----------------------------------------------------------------------------

module light_ramp_pump_scheduler_tb;
  import lrps_pkg::*;

  // Run shape. The slowest correct item is its work on a ramp plus the longest
  // sender gap plus the longest receiver stall. About 750 items therefore fit
  // well inside the limit below, even with every drain added.
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 60;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 91;

  // One result item: four light levels, then the two pumps.
  typedef struct packed {
    logic [DRV_W-1:0] red;
    logic [DRV_W-1:0] green;
    logic [DRV_W-1:0] blue;
    logic [DRV_W-1:0] white;
    logic [DRV_W-1:0] pump_one;
    logic [DRV_W-1:0] pump_two;
  } drive_set_t;

  localparam drive_set_t ALL_OFF = '0;

  // A row of the directed table is either a tick or a register write.
  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [HOUR_W-1:0]     hour;
    logic [MIN_W-1:0]      minute;
    logic [NOW_W-1:0]      now;
    bit                    typed;
    drive_set_t            want;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_data;
  } plan_row_t;

  // Clock, reset and every block input start at a known value.
  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [HOUR_W-1:0]    in_hour_now   = '0;
  logic [MIN_W-1:0]     in_minute_now = '0;
  logic [NOW_W-1:0]     in_now_ms     = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [DRV_W-1:0]     out_red_level;
  logic [DRV_W-1:0]     out_green_level;
  logic [DRV_W-1:0]     out_blue_level;
  logic [DRV_W-1:0]     out_white_level;
  logic [DRV_W-1:0]     out_pump_one_drive;
  logic [DRV_W-1:0]     out_pump_two_drive;

  light_ramp_pump_scheduler DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_hour_now        (in_hour_now),
    .in_minute_now      (in_minute_now),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_red_level      (out_red_level),
    .out_green_level    (out_green_level),
    .out_blue_level     (out_blue_level),
    .out_white_level    (out_white_level),
    .out_pump_one_drive (out_pump_one_drive),
    .out_pump_two_drive (out_pump_two_drive)
  );

  // Expected drive sets, oldest first, and the run bookkeeping.
  drive_set_t levels_due[$];
  plan_row_t  plan[$];
  int         mismatches  = 0;
  int         sent_total  = 0;
  int         cycle_count = 0;
  bit         tx_fast     = 1'b0;

  // Shadow copy of the registers and the pump state, as the block should
  // hold them.
  logic [CFG_W-1:0]   lamp_pct_cfg;
  logic [HOUR_W-1:0]  start_hour_cfg;
  logic [HOUR_W-1:0]  end_hour_cfg;
  logic [RAMP_W-1:0]  ramp_cfg;
  logic [SETUP_W-1:0] pump_one_cfg;
  logic [SETUP_W-1:0] pump_two_cfg;
  logic               pump_one_live;
  logic [NOW_W-1:0]   pump_one_t0;
  logic               pump_two_live;
  logic [NOW_W-1:0]   pump_two_t0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  task automatic reset_shadow();
    lamp_pct_cfg   = 28'd0;
    start_hour_cfg = 5'd8;
    end_hour_cfg   = 5'd20;
    ramp_cfg       = 7'd30;
    pump_one_cfg   = 18'd102569;
    pump_two_cfg   = 18'd102575;
    pump_one_live  = 1'b0;
    pump_one_t0    = '0;
    pump_two_live  = 1'b0;
    pump_two_t0    = '0;
  endtask

  // A percent above 100 counts as 100, so a drive never passes 255.
  function automatic int pct_drive(input logic [PCT_W-1:0] pct);
    int p;
    p = (pct > 7'd100) ? 100 : int'(pct);
    return p * 255 / 100;
  endfunction

  // Trapezoid over minute of day: rise, hold, fall, else dark. The windows
  // are tested in that order, and a zero ramp leaves both ramps empty.
  function automatic logic [DRV_W-1:0] ramp_level(input logic [PCT_W-1:0] pct,
                                                  input int cm);
    int sm, em, tr, se, ss, full;
    sm   = int'(start_hour_cfg) * 60;
    em   = int'(end_hour_cfg) * 60;
    tr   = int'(ramp_cfg);
    se   = sm + tr;
    ss   = em - tr;
    full = pct_drive(pct);
    if (cm >= sm && cm < se && tr > 0)
      return DRV_W'(full * (cm - sm) / tr);
    if (cm >= se && cm < ss)
      return DRV_W'(full);
    if (cm >= ss && cm < em && tr > 0)
      return DRV_W'(full * (tr - (cm - ss)) / tr);
    return '0;
  endfunction

  // A pump arms on its hour at minute 0, latching the timestamp on the tick
  // that arms it, and disarms on any other tick. The elapsed time wraps at
  // 32 bits, just like the timestamp.
  function automatic logic [DRV_W-1:0] pump_drive(input logic [SETUP_W-1:0] setup,
                                                  input logic [HOUR_W-1:0] hr,
                                                  input logic [MIN_W-1:0] mn,
                                                  input logic [NOW_W-1:0] now,
                                                  inout logic live,
                                                  inout logic [NOW_W-1:0] t0);
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W-1:0] run_ms;
    if (hr == setup[4:0] && mn == '0) begin
      if (!live) begin
        live = 1'b1;
        t0   = now;
      end
    end else begin
      live = 1'b0;
    end
    elapsed = now - t0;
    run_ms  = NOW_W'(setup[10:5]) * 32'd1000;
    if (live && elapsed < run_ms)
      return DRV_W'(pct_drive(setup[17:11]));
    return '0;
  endfunction

  function automatic drive_set_t predict_tick(input logic [HOUR_W-1:0] hr,
                                              input logic [MIN_W-1:0] mn,
                                              input logic [NOW_W-1:0] now);
    drive_set_t d;
    int         cm;
    cm         = int'(hr) * 60 + int'(mn);
    d.red      = ramp_level(lamp_pct_cfg[6:0], cm);
    d.green    = ramp_level(lamp_pct_cfg[13:7], cm);
    d.blue     = ramp_level(lamp_pct_cfg[20:14], cm);
    d.white    = ramp_level(lamp_pct_cfg[27:21], cm);
    d.pump_one = pump_drive(pump_one_cfg, hr, mn, now, pump_one_live, pump_one_t0);
    d.pump_two = pump_drive(pump_two_cfg, hr, mn, now, pump_two_live, pump_two_t0);
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Idle lengths: half of them zero, most others short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Writes one register at the next edge and mirrors it in the shadow copy.
  // Only called while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_LIGHT_LEVELS: lamp_pct_cfg   = data;
      REG_START_HOUR:   start_hour_cfg = data[HOUR_W-1:0];
      REG_END_HOUR:     end_hour_cfg   = data[HOUR_W-1:0];
      REG_RAMP_MINUTES: ramp_cfg       = data[RAMP_W-1:0];
      REG_PUMP_ONE:     pump_one_cfg   = data[SETUP_W-1:0];
      REG_PUMP_TWO:     pump_two_cfg   = data[SETUP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Presents one tick and holds it until it is taken. The valid line is left
  // high on return, so a back-to-back item never drops it for one step. The
  // expectation is queued on the edge that takes the item, which keeps the
  // pump state in step with the block.
  task automatic send_tick(input logic [HOUR_W-1:0] hr,
                           input logic [MIN_W-1:0] mn,
                           input logic [NOW_W-1:0] now,
                           input bit typed,
                           input drive_set_t want);
    int         idle;
    drive_set_t guess;
    idle = tx_fast ? 0 : gap_len();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_hour_now   <= hr;
    in_minute_now <= mn;
    in_now_ms     <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    guess = predict_tick(hr, mn, now);
    levels_due.push_back(typed ? want : guess);
    sent_total++;
  endtask

  // Stops sending and waits for every expected item, then lets the block
  // settle. Register writes only follow this.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A pump run: a stretch of minute-0 ticks on one pump's hour with the time
  // stepping forward, sometimes near the wrap of the timestamp, sometimes
  // with a wild jump. It is closed by a tick that disarms the pump.
  task automatic send_pump_run();
    logic [SETUP_W-1:0] setup;
    logic [NOW_W-1:0]   now;
    int                 len;
    setup = $urandom_range(0, 1) ? pump_one_cfg : pump_two_cfg;
    case ($urandom_range(0, 3))
      0:       now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      1:       now = $urandom_range(0, 3000);
      default: now = $urandom();
    endcase
    len = $urandom_range(3, 10);
    repeat (len) begin
      send_tick(setup[4:0], '0, now, 1'b0, ALL_OFF);
      if ($urandom_range(0, 9) == 0)
        now = now + $urandom();
      else
        now = now + $urandom_range(0, 2500);
    end
    if ($urandom_range(0, 1))
      send_tick(setup[4:0], MIN_W'($urandom_range(1, 63)), now, 1'b0, ALL_OFF);
    else
      send_tick(setup[4:0] + 5'd1, '0, now, 1'b0, ALL_OFF);
  endtask

  // A tick near the start or the end of the light window, where the ramps
  // and the hold edges sit.
  task automatic send_light_tick();
    int mark, cm, tr;
    tr   = int'(ramp_cfg);
    mark = $urandom_range(0, 1) ? int'(start_hour_cfg) * 60 : int'(end_hour_cfg) * 60;
    cm   = mark + int'($urandom_range(0, 2 * tr + 20)) - tr - 10;
    if (cm < 0) cm = 0;
    if (cm > 1919) cm = 1919;
    send_tick(HOUR_W'(cm / 60), MIN_W'(cm % 60), $urandom(), 1'b0, ALL_OFF);
  endtask

  // One register setting per random phase. The first three are extremes;
  // the rest are random, mostly inside the documented ranges.
  task automatic apply_setting(input int phase);
    logic [CFG_W-1:0]   lv;
    logic [HOUR_W-1:0]  sh, eh;
    logic [RAMP_W-1:0]  rm;
    logic [SETUP_W-1:0] p1, p2;
    case (phase)
      0: begin
        lv = 28'hFFF_FFFF;
        sh = 5'd0;
        eh = 5'd23;
        rm = 7'd120;
        p1 = {7'd100, 6'd60, 5'd0};
        p2 = {7'd127, 6'd63, 5'd23};
      end
      1: begin
        lv = 28'hFFF_FFFF;
        sh = 5'd31;
        eh = 5'd31;
        rm = 7'd127;
        p1 = 18'h3FFFF;
        p2 = 18'h00000;
      end
      2: begin
        lv = {7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              7'($urandom_range(0, 127)), 7'($urandom_range(0, 127))};
        sh = 5'd0;
        eh = 5'd0;
        rm = 7'd1;
        p1 = {7'd0, 6'd1, 5'd0};
        p2 = {7'd1, 6'd1, 5'd0};
      end
      default: begin
        lv = {7'($urandom_range(0, 110)), 7'($urandom_range(0, 110)),
              7'($urandom_range(0, 110)), 7'($urandom_range(0, 110))};
        sh = ($urandom_range(0, 7) == 0) ? HOUR_W'($urandom()) : HOUR_W'($urandom_range(0, 23));
        eh = ($urandom_range(0, 7) == 0) ? HOUR_W'($urandom()) : HOUR_W'($urandom_range(0, 23));
        rm = ($urandom_range(0, 9) == 0) ? 7'd0 : 7'($urandom_range(1, 120));
        p1 = {7'($urandom_range(0, 110)), 6'($urandom_range(1, 60)),
              5'($urandom_range(0, 23))};
        p2 = {7'($urandom_range(0, 110)), 6'($urandom_range(1, 60)),
              5'($urandom_range(0, 23))};
      end
    endcase
    write_reg(REG_LIGHT_LEVELS, lv);
    write_reg(REG_START_HOUR, CFG_W'(sh));
    write_reg(REG_END_HOUR, CFG_W'(eh));
    write_reg(REG_RAMP_MINUTES, CFG_W'(rm));
    write_reg(REG_PUMP_ONE, CFG_W'(p1));
    write_reg(REG_PUMP_TWO, CFG_W'(p2));
  endtask

  // Directed table builders.
  task automatic add_tick(input logic [HOUR_W-1:0] hr, input logic [MIN_W-1:0] mn,
                          input logic [NOW_W-1:0] now, input bit typed,
                          input drive_set_t want);
    plan_row_t r;
    r.kind     = ROW_TICK;
    r.hour     = hr;
    r.minute   = mn;
    r.now      = now;
    r.typed    = typed;
    r.want     = want;
    r.reg_idx  = '0;
    r.reg_data = '0;
    plan.push_back(r);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    plan_row_t r;
    r.kind     = ROW_CFG;
    r.hour     = '0;
    r.minute   = '0;
    r.now      = '0;
    r.typed    = 1'b0;
    r.want     = ALL_OFF;
    r.reg_idx  = idx;
    r.reg_data = data;
    plan.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The receiver alternates between windows where it is always ready and
  // windows with random stalls, so that stalls land on every step of the
  // block's work as well as on waiting results.
  initial begin : result_sink
    int stall_left;
    int window;
    bit rx_fast;
    stall_left = 0;
    window     = 0;
    rx_fast    = 1'b0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        rx_fast = ($urandom_range(0, 3) == 0);
        window  = $urandom_range(100, 400);
      end
      window--;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = rx_fast ? 0 : gap_len();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic check_level(input string name, input logic [DRV_W-1:0] want,
                             input logic [DRV_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Scores each accepted result against the oldest expectation. Values are
  // read just after the edge, which is what the block saw at that edge.
  always @(posedge clk) begin
    drive_set_t exp_set;
    if (rst_n && out_valid && out_ready) begin
      if (levels_due.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %0d %0d %0d %0d %0d %0d",
                 $time, out_red_level, out_green_level, out_blue_level,
                 out_white_level, out_pump_one_drive, out_pump_two_drive);
        mismatches++;
      end else begin
        exp_set = levels_due.pop_front();
        check_level("red_level", exp_set.red, out_red_level);
        check_level("green_level", exp_set.green, out_green_level);
        check_level("blue_level", exp_set.blue, out_blue_level);
        check_level("white_level", exp_set.white, out_white_level);
        check_level("pump_one_drive", exp_set.pump_one, out_pump_one_drive);
        check_level("pump_two_drive", exp_set.pump_two, out_pump_two_drive);
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, levels_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Clock and main sequence
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : main_seq
    int phase;
    int goal;
    int pick;
    reset_shadow();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. With the register defaults all lights are dark, so the
    // first rows only exercise the pumps: arming, the last millisecond of a
    // run, the first one past it, disarming, and a run across the wrap of
    // the timestamp.
    add_tick(5'd0, 6'd0, 32'd0, 1'b1, ALL_OFF);
    add_tick(5'd9, 6'd0, 32'd1000, 1'b1, drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd127, 8'd0});
    add_tick(5'd9, 6'd0, 32'd5999, 1'b1, drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd127, 8'd0});
    add_tick(5'd9, 6'd0, 32'd6000, 1'b1, ALL_OFF);
    add_tick(5'd9, 6'd1, 32'd6001, 1'b1, ALL_OFF);
    add_tick(5'd15, 6'd0, 32'hFFFF_F000, 1'b1,
             drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127});
    add_tick(5'd15, 6'd0, 32'h0000_0387, 1'b1,
             drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127});
    add_tick(5'd15, 6'd0, 32'h0000_0388, 1'b1, ALL_OFF);
    // Lights on: red at 100, green above 100 so it saturates, blue at half,
    // white at one percent. Walk the ramps and the hold window.
    add_cfg(REG_LIGHT_LEVELS, {7'd1, 7'd50, 7'd127, 7'd100});
    add_tick(5'd8, 6'd0, 32'd7, 1'b0, ALL_OFF);
    add_tick(5'd8, 6'd15, 32'd8, 1'b0, ALL_OFF);
    add_tick(5'd8, 6'd30, 32'd9, 1'b1, drive_set_t'{8'd255, 8'd255, 8'd127, 8'd2, 8'd0, 8'd0});
    add_tick(5'd19, 6'd30, 32'd10, 1'b0, ALL_OFF);
    add_tick(5'd19, 6'd59, 32'd11, 1'b0, ALL_OFF);
    add_tick(5'd20, 6'd0, 32'd12, 1'b1, ALL_OFF);
    // Zero ramp: full from start to end without any division.
    add_cfg(REG_RAMP_MINUTES, 28'd0);
    add_tick(5'd8, 6'd0, 32'd13, 1'b0, ALL_OFF);
    add_tick(5'd19, 6'd59, 32'd14, 1'b0, ALL_OFF);
    // End hour before start hour leaves no hold window.
    add_cfg(REG_START_HOUR, 28'd20);
    add_cfg(REG_END_HOUR, 28'd8);
    add_cfg(REG_RAMP_MINUTES, 28'd30);
    add_tick(5'd21, 6'd0, 32'd15, 1'b0, ALL_OFF);
    // Pump one with every setup bit set: hour 31, 63 seconds and a power
    // above 100 that saturates to full drive.
    add_cfg(REG_PUMP_ONE, 28'h3FFFF);
    add_tick(5'd31, 6'd0, 32'd0, 1'b1, drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
    add_tick(5'd31, 6'd0, 32'd62999, 1'b1, drive_set_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0});
    add_tick(5'd31, 6'd0, 32'd63000, 1'b1, ALL_OFF);
    // Pump two with zero seconds never drives.
    add_cfg(REG_PUMP_TWO, CFG_W'({7'd100, 6'd0, 5'd3}));
    add_tick(5'd3, 6'd0, 32'd5, 1'b1, ALL_OFF);
    add_tick(5'd3, 6'd63, 32'hA5A5_5A5A, 1'b0, ALL_OFF);
    add_tick(5'd31, 6'd63, 32'hFFFF_FFFF, 1'b0, ALL_OFF);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_for_quiet();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_tick(plan[i].hour, plan[i].minute, plan[i].now, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting. Most items are
    // well-formed pump runs and ticks near the ramps; the rest is noise over
    // the whole field ranges.
    for (phase = 0; phase < PHASES; phase++) begin
      wait_for_quiet();
      apply_setting(phase);
      tx_fast = ($urandom_range(0, 3) == 0);
      goal    = sent_total + ITEMS_PER_PHASE;
      while (sent_total < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)
          send_pump_run();
        else if (pick < 8)
          send_light_tick();
        else
          send_tick(HOUR_W'($urandom()), MIN_W'($urandom()), $urandom(), 1'b0, ALL_OFF);
        if ($urandom_range(0, 49) == 0) wait_for_quiet();
      end
    end

    wait_for_quiet();
    if (mismatches == 0 && levels_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
